>>> design/dmc_pkg.sv
package dmc_pkg;

    // Cache geometry.
    localparam int LINES         = 1024;
    localparam int INDEX_W       = $clog2(LINES);
    localparam int ADDR_MAX_BITS = 40;
    localparam int ADDR_W        = 40;
    localparam int TAG_W         = 40;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 32;
    localparam int CYC_W         = 40;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_ADDRESS_BITS   = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS     = 2'd1;
    localparam logic [1:0] REG_MEMORY_LATENCY = 2'd2;
    localparam logic [1:0] REG_CACHE_LATENCY  = 2'd3;

    localparam logic [5:0] RST_ADDRESS_BITS   = 6'd32;
    localparam logic [3:0] RST_INDEX_BITS     = 4'd10;
    localparam logic [7:0] RST_MEMORY_LATENCY = 8'd130;
    localparam logic [3:0] RST_CACHE_LATENCY  = 4'd10;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] line_data;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
        logic [CNT_W-1:0]  access_total;
        logic [CYC_W-1:0]  cycle_sum;
    } t_rsp;

    // One cache line as held in the line memory.
    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] word;
    } t_line;

    localparam int LINE_W = $bits(t_line);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

>>> design/direct_mapped_cache_lookup_unit.sv
// Direct-mapped cache lookup with access statistics.
//
// Input channel: i_valid / o_ready carry one item (address, write_data).
// Output channel: o_valid / i_ready carry one result item (hit flag, line
// data after the access, and the hit, miss, access and cycle totals).
// Configuration goes through the APB port; pready is always high and the
// four registers sit at byte addresses 0, 4, 8 and 12.
//
// The line memory is read in the cycle the item is accepted; in the lookup
// state the tag is compared, the line is filled on a miss and the result
// is registered. The single-port-read line memory and its registered read
// set this, so a new item is taken only after the lookup of the last one
// has finished. The result register lets the next item be accepted while a
// result still waits; if the receiver stalls, the lookup holds until the
// result register frees up, and o_ready stays low meanwhile.
//
// After reset the block sweeps all 1024 entries of the line memory, clearing
// one valid bit per cycle, before o_ready rises. Configuration writes are
// taken during that sweep. Reset also zeroes all counters.
module direct_mapped_cache_lookup_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  dmc_pkg::t_req                        i_req,

    output logic                                 o_valid,
    input  logic                                 i_ready,
    output dmc_pkg::t_rsp                        o_rsp,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dmc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [dmc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [dmc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int IW = dmc_pkg::INDEX_W;

    // Configuration registers.
    logic [5:0] r_address_bits;
    logic [3:0] r_index_bits;
    logic [7:0] r_memory_latency;
    logic [3:0] r_cache_latency;

    // Control state.
    dmc_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_clr_idx;
    logic            r_out_valid;

    // Item held during the lookup.
    logic [IW-1:0]                r_line;
    logic [dmc_pkg::TAG_W-1:0]    r_tag;
    logic [dmc_pkg::DATA_W-1:0]   r_data;

    // Statistics.
    logic [dmc_pkg::CNT_W-1:0] r_hit_cnt, n_hit_cnt;
    logic [dmc_pkg::CNT_W-1:0] r_miss_cnt, n_miss_cnt;
    logic [dmc_pkg::CNT_W-1:0] r_acc_cnt, n_acc_cnt;
    logic [dmc_pkg::CYC_W-1:0] r_cyc_cnt, n_cyc_cnt;

    dmc_pkg::t_rsp r_rsp;

    // Line memory signals.
    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [IW-1:0]              ram_raddr;
    dmc_pkg::t_line             ram_wline;
    logic [dmc_pkg::LINE_W-1:0] ram_rdata;
    dmc_pkg::t_line             rd_line;

    logic                       in_accept;
    logic                       out_free;
    logic                       finish;
    logic                       hit;
    logic [3:0]                 use_ib;
    logic [5:0]                 use_ab;
    logic [dmc_pkg::ADDR_W-1:0] addr_mask;
    logic [dmc_pkg::ADDR_W-1:0] line_mask;
    logic [dmc_pkg::TAG_W-1:0]  req_tag;
    logic [IW-1:0]              req_line;
    logic [8:0]                 cyc_add;
    logic [dmc_pkg::CYC_W:0]    cyc_sum;
    logic                       cfg_write;

    function automatic logic [dmc_pkg::CNT_W-1:0] sat_inc(
        input logic [dmc_pkg::CNT_W-1:0] value
    );
        return (&value) ? value : value + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_bits   <= dmc_pkg::RST_ADDRESS_BITS;
            r_index_bits     <= dmc_pkg::RST_INDEX_BITS;
            r_memory_latency <= dmc_pkg::RST_MEMORY_LATENCY;
            r_cache_latency  <= dmc_pkg::RST_CACHE_LATENCY;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                dmc_pkg::REG_ADDRESS_BITS:   r_address_bits   <= pwdata[5:0];
                dmc_pkg::REG_INDEX_BITS:     r_index_bits     <= pwdata[3:0];
                dmc_pkg::REG_MEMORY_LATENCY: r_memory_latency <= pwdata[7:0];
                dmc_pkg::REG_CACHE_LATENCY:  r_cache_latency  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            dmc_pkg::REG_ADDRESS_BITS:   prdata[5:0] = r_address_bits;
            dmc_pkg::REG_INDEX_BITS:     prdata[3:0] = r_index_bits;
            dmc_pkg::REG_MEMORY_LATENCY: prdata[7:0] = r_memory_latency;
            dmc_pkg::REG_CACHE_LATENCY:  prdata[3:0] = r_cache_latency;
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Index and tag split of the incoming address
    // ------------------------------------------------------------------
    // The index width is limited to what the line memory can address and
    // the address width to the widest address the block takes. Masking the
    // address to its used width before shifting out the index gives an
    // empty tag whenever the address width does not exceed the index width.
    assign use_ib = (r_index_bits > 4'(IW)) ? 4'(IW) : r_index_bits;
    assign use_ab = (r_address_bits > 6'(dmc_pkg::ADDR_MAX_BITS))
                  ? 6'(dmc_pkg::ADDR_MAX_BITS) : r_address_bits;

    assign addr_mask = ~({dmc_pkg::ADDR_W{1'b1}} << use_ab);
    assign line_mask = ~({dmc_pkg::ADDR_W{1'b1}} << use_ib);
    assign req_tag   = dmc_pkg::TAG_W'((i_req.address & addr_mask) >> use_ib);
    assign req_line  = IW'(i_req.address & line_mask);

    // ------------------------------------------------------------------
    // Handshakes and sequencing
    // ------------------------------------------------------------------
    assign o_ready   = (r_state == dmc_pkg::ST_IDLE);
    assign in_accept = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign finish    = (r_state == dmc_pkg::ST_LOOKUP) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmc_pkg::ST_CLEAR: begin
                if (&r_clr_idx) begin
                    n_state = dmc_pkg::ST_IDLE;
                end
            end
            dmc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = dmc_pkg::ST_LOOKUP;
                end
            end
            dmc_pkg::ST_LOOKUP: begin
                if (out_free) begin
                    n_state = dmc_pkg::ST_IDLE;
                end
            end
            default: n_state = dmc_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmc_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == dmc_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The item is captured at acceptance; the split uses the configuration
    // of that moment.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_line <= req_line;
            r_tag  <= req_tag;
            r_data <= i_req.write_data;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: valid bit, tag and word in one entry
    // ------------------------------------------------------------------
    // While a lookup waits on a stalled receiver, the same entry is read
    // again every cycle, so the read data stays current. A fill is written
    // as the lookup completes, before the next item can be read.
    assign ram_raddr = (r_state == dmc_pkg::ST_IDLE) ? req_line : r_line;
    assign rd_line   = dmc_pkg::t_line'(ram_rdata);
    assign hit       = rd_line.valid && (rd_line.tag == r_tag);

    always_comb begin
        if (r_state == dmc_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wline = '0;
        end else begin
            ram_we          = finish && !hit;
            ram_waddr       = r_line;
            ram_wline.valid = 1'b1;
            ram_wline.tag   = r_tag;
            ram_wline.word  = r_data;
        end
    end

    dmc_ram #(
        .WIDTH (dmc_pkg::LINE_W),
        .DEPTH (dmc_pkg::LINES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wline),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Statistics, all saturating
    // ------------------------------------------------------------------
    always_comb begin
        n_hit_cnt  = hit ? sat_inc(r_hit_cnt) : r_hit_cnt;
        n_miss_cnt = hit ? r_miss_cnt : sat_inc(r_miss_cnt);
        n_acc_cnt  = sat_inc(r_acc_cnt);
        cyc_add    = hit ? 9'(r_cache_latency)
                         : 9'(r_memory_latency) + 9'(r_cache_latency);
        cyc_sum    = {1'b0, r_cyc_cnt} + (dmc_pkg::CYC_W + 1)'(cyc_add);
        n_cyc_cnt  = cyc_sum[dmc_pkg::CYC_W] ? '1 : cyc_sum[dmc_pkg::CYC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_acc_cnt  <= '0;
            r_cyc_cnt  <= '0;
        end else if (finish) begin
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
            r_acc_cnt  <= n_acc_cnt;
            r_cyc_cnt  <= n_cyc_cnt;
        end
    end

    // Result register. On a miss the line now holds the new word.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_rsp.hit          <= hit;
            r_rsp.line_data    <= hit ? rd_line.word : r_data;
            r_rsp.hit_total    <= n_hit_cnt;
            r_rsp.miss_total   <= n_miss_cnt;
            r_rsp.access_total <= n_acc_cnt;
            r_rsp.cycle_sum    <= n_cyc_cnt;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

>>> design/dmc_ram.sv
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
